FILE: design/proximity_led_bar_controller_macros.svh
// ----------------------------------------------------------------------------
// proximity led bar controller assertion macros
// shared assertion forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_LED_BAR_CONTROLLER_MACROS_SVH
`define PROXIMITY_LED_BAR_CONTROLLER_MACROS_SVH

// same-cycle implication
`define PLBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plbc: check failed");

// next-cycle implication
`define PLBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plbc: check failed");

`endif

FILE: design/plbc_pkg.sv
// ----------------------------------------------------------------------------
// plbc_pkg
// shared widths, command codes, transaction types and duty mapping functions
// ----------------------------------------------------------------------------
`default_nettype none

package plbc_pkg;

  localparam int DUTY_W    = 10;
  localparam int HOLD_W    = 10;
  localparam int DIST_W    = 10;
  localparam int FUNC_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 10;
  localparam int NUM_LED   = 4;
  localparam int STEP_W    = 5;
  localparam int TOTAL_W   = 12;
  localparam int KIND_W    = 2;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;

  localparam logic [DUTY_W-1:0]  FULL_DUTY   = 10'd1000;
  localparam logic [DIST_W-1:0]  NEAR_CM     = 10'd5;
  localparam logic [DIST_W-1:0]  FAR_CM      = 10'd30;
  localparam logic [TOTAL_W-1:0] STEP_PER_CM = 12'd160;

  // input function codes
  localparam logic [FUNC_W-1:0] FN_TICK     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DISTANCE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_OBS_ON   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_OBS_OFF  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CASCADE  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_FLASH    = 3'd6;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CASCADE_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_MS   = 1'b1;

  localparam logic [CFG_W-1:0] CASCADE_MS_RST = 10'd75;
  localparam logic [CFG_W-1:0] FLASH_MS_RST   = 10'd100;

  // command kinds carried from front to back
  localparam logic [KIND_W-1:0] CMD_SINGLE  = 2'd0;
  localparam logic [KIND_W-1:0] CMD_CASCADE = 2'd1;
  localparam logic [KIND_W-1:0] CMD_FLASH   = 2'd2;

  // final step of each pattern
  localparam logic [STEP_W-1:0] CASCADE_LAST = 5'd19;
  localparam logic [STEP_W-1:0] FLASH_LAST   = 5'd10;

  typedef logic [NUM_LED-1:0][DUTY_W-1:0] duty_vec_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    duty_vec_t         duty;
  } cmd_t;

  typedef struct packed {
    duty_vec_t         duty;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } frame_t;

  // all leds full or all off
  function automatic duty_vec_t all_duty(input logic on);
    duty_vec_t res;
    for (int i = 0; i < NUM_LED; i++) begin
      res[i] = on ? FULL_DUTY : '0;
    end
    return res;
  endfunction

  // distance to bar graph, led4 fills first
  function automatic duty_vec_t bar_map(input logic [DIST_W-1:0] dist_cm);
    duty_vec_t           res;
    logic [TOTAL_W-1:0]  total;
    logic [TOTAL_W-1:0]  full_ext;
    full_ext = TOTAL_W'(FULL_DUTY);
    total    = '0;
    res      = '0;
    if (dist_cm > FAR_CM) begin
      res = '0;
    end else if (dist_cm <= NEAR_CM) begin
      res = all_duty(1'b1);
    end else begin
      total = TOTAL_W'(FAR_CM - dist_cm) * STEP_PER_CM;
      for (int i = NUM_LED - 1; i >= 0; i--) begin
        if (total > full_ext) begin
          res[i] = FULL_DUTY;
          total  = total - full_ext;
        end else begin
          res[i] = DUTY_W'(total);
          total  = '0;
        end
      end
    end
    return res;
  endfunction

  // lit led of each cascade sweep step, led1 is bit 0
  function automatic logic [NUM_LED-1:0] sweep_mask(input logic [STEP_W-1:0] step);
    logic [NUM_LED-1:0] mask;
    case (step) inside
      5'd1, 5'd7, 5'd13:             mask = 4'b0001;
      5'd2, 5'd6, 5'd8, 5'd12, 5'd14, 5'd18: mask = 4'b0010;
      5'd3, 5'd5, 5'd9, 5'd11, 5'd15, 5'd17: mask = 4'b0100;
      5'd4, 5'd10, 5'd16:            mask = 4'b1000;
      default:                       mask = 4'b0000;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

FILE: design/plbc_front.sv
// ----------------------------------------------------------------------------
// plbc_front
// accepts commands, keeps obstacle, blink and saved duty state, and queues
// the frame work that each command causes
// ----------------------------------------------------------------------------
`default_nettype none

module plbc_front
  import plbc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [DIST_W-1:0] in_distance_cm,
  output logic                   in_full,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  logic      obstacle_r, obstacle_nxt;
  logic      blink_r, blink_nxt;
  duty_vec_t saved_r, saved_nxt;
  duty_vec_t map;
  logic      accept;

  assign in_full = q_full;
  assign accept  = in_push & ~q_full;
  assign map     = bar_map(in_distance_cm);

  // command decode and state update
  always_comb begin
    obstacle_nxt = obstacle_r;
    blink_nxt    = blink_r;
    saved_nxt    = saved_r;
    q_push       = 1'b0;
    q_cmd.kind   = CMD_SINGLE;
    q_cmd.duty   = saved_r;
    if (accept) begin
      unique case (in_func)
        FN_TICK: begin
          if (obstacle_r) begin
            blink_nxt  = ~blink_r;
            q_push     = 1'b1;
            q_cmd.duty = all_duty(~blink_r);
          end
        end
        FN_CLEAR: begin
          saved_nxt = '0;
          if (!obstacle_r) begin
            q_push     = 1'b1;
            q_cmd.duty = '0;
          end
        end
        FN_DISTANCE: begin
          saved_nxt = map;
          if (!obstacle_r) begin
            q_push     = 1'b1;
            q_cmd.duty = map;
          end
        end
        FN_OBS_ON: begin
          obstacle_nxt = 1'b1;
        end
        FN_OBS_OFF: begin
          obstacle_nxt = 1'b0;
          q_push       = 1'b1;
        end
        FN_CASCADE: begin
          obstacle_nxt = 1'b0;
          q_push       = 1'b1;
          q_cmd.kind   = CMD_CASCADE;
        end
        FN_FLASH: begin
          obstacle_nxt = 1'b0;
          q_push       = 1'b1;
          q_cmd.kind   = CMD_FLASH;
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_r <= 1'b0;
      blink_r    <= 1'b0;
      saved_r    <= '0;
    end else begin
      obstacle_r <= obstacle_nxt;
      blink_r    <= blink_nxt;
      saved_r    <= saved_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/plbc_cmdq.sv
// ----------------------------------------------------------------------------
// plbc_cmdq
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module plbc_cmdq
  import plbc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      rd_cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full   = count_r == (QPTR_W + 1)'(QDEPTH);
  assign empty  = count_r == '0;
  assign rd_cmd = mem[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = (QPTR_W + 1)'(count_r + 1'b1);
    end else if (!push && pop) begin
      count_nxt = (QPTR_W + 1)'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: design/plbc_back.sv
// ----------------------------------------------------------------------------
// plbc_back
// frame sequencer: turns queued commands into timed frames in an output
// register, one per cycle while unstalled; holds the step time config registers
// ----------------------------------------------------------------------------
`default_nettype none

module plbc_back
  import plbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 q_empty,
  input  wire cmd_t                 q_cmd,
  output logic                      q_pop,
  input  wire logic                 out_pop,
  output logic                      out_empty,
  output frame_t                    out_frame
);

  logic [CFG_W-1:0]  cascade_ms_r, cascade_ms_nxt;
  logic [CFG_W-1:0]  flash_ms_r, flash_ms_nxt;
  logic              busy_r, busy_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  frame_t            out_frame_r, out_frame_nxt;

  cmd_t               cmd;
  logic [STEP_W-1:0]  step;
  logic [NUM_LED-1:0] mask;
  frame_t             frame;
  logic               load;

  assign out_empty = ~out_valid_r;
  assign out_frame = out_frame_r;

  // config writes
  always_comb begin
    cascade_ms_nxt = cascade_ms_r;
    flash_ms_nxt   = flash_ms_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CASCADE_MS: cascade_ms_nxt = cfg_wdata;
        CFG_FLASH_MS:   flash_ms_nxt   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // current command and step, straight from the queue when idle
  assign cmd  = busy_r ? cur_r : q_cmd;
  assign step = busy_r ? step_r : '0;
  assign mask = sweep_mask(step);
  assign load = (busy_r | ~q_empty) & (~out_valid_r | out_pop);

  // frame generation
  always_comb begin
    frame.duty = cmd.duty;
    frame.hold = '0;
    frame.last = 1'b1;
    unique case (cmd.kind)
      CMD_CASCADE: begin
        if (step == '0) begin
          frame.duty = '0;
          frame.last = 1'b0;
        end else if (step != CASCADE_LAST) begin
          for (int i = 0; i < NUM_LED; i++) begin
            frame.duty[i] = mask[i] ? FULL_DUTY : '0;
          end
          frame.hold = cascade_ms_r;
          frame.last = 1'b0;
        end
      end
      CMD_FLASH: begin
        if (step != FLASH_LAST) begin
          frame.duty = all_duty(~step[0]);
          frame.hold = flash_ms_r;
          frame.last = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and output register control
  always_comb begin
    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    out_frame_nxt = out_frame_r;
    out_valid_nxt = out_valid_r & ~out_pop;
    q_pop         = load & ~busy_r;
    if (load) begin
      out_frame_nxt = frame;
      out_valid_nxt = 1'b1;
      if (!busy_r) begin
        cur_nxt = q_cmd;
      end
      if (frame.last) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        step_nxt = STEP_W'(step + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cascade_ms_r <= CASCADE_MS_RST;
      flash_ms_r   <= FLASH_MS_RST;
      busy_r       <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cascade_ms_r <= cascade_ms_nxt;
      flash_ms_r   <= flash_ms_nxt;
      busy_r       <= busy_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    out_frame_r <= out_frame_nxt;
  end

endmodule

`default_nettype wire

FILE: design/proximity_led_bar_controller.sv
// ----------------------------------------------------------------------------
// proximity_led_bar_controller
// Command events in (in_push/in_full), LED duty frames out (out_empty/out_pop),
// step times written through cfg_we/cfg_index/cfg_wdata by the user between
// transactions; the block does not enforce this. A command is taken whenever
// in_full is low; the front updates obstacle, blink and saved duty state at once
// and queues the frame work in a two-entry command queue. The back sequencer
// emits one frame per cycle into an output register while it is empty or
// popped; a command's first frame goes through the queue, then that register.
// Single-frame commands sustain one per cycle; a cascade occupies the sequencer
// for 20 frames and a flash for 11, so in_full rises once two commands wait
// behind it. When out_pop stays low the frame holds and the queue fills, then
// in_full goes high. Synchronous reset (rst_n low) clears the state, empties
// the queue and the output register and loads step times of 75 and 100 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module proximity_led_bar_controller
  import plbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [DIST_W-1:0]    in_distance_cm,
  output logic                      in_full,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [DUTY_W-1:0]         out_led1_duty,
  output logic [DUTY_W-1:0]         out_led2_duty,
  output logic [DUTY_W-1:0]         out_led3_duty,
  output logic [DUTY_W-1:0]         out_led4_duty,
  output logic [HOLD_W-1:0]         out_hold_ms,
  output logic                      out_last_frame,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic   q_push, q_full, q_pop, q_empty;
  cmd_t   q_wr_cmd, q_rd_cmd;
  frame_t frame;

  // front: accept and classify
  plbc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_func        (in_func),
    .in_distance_cm (in_distance_cm),
    .in_full        (in_full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_wr_cmd)
  );

  // command queue
  plbc_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_rd_cmd)
  );

  // back: frame sequencer
  plbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_cmd     (q_rd_cmd),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_frame (frame)
  );

  // result fields
  assign out_led1_duty  = frame.duty[0];
  assign out_led2_duty  = frame.duty[1];
  assign out_led3_duty  = frame.duty[2];
  assign out_led4_duty  = frame.duty[3];
  assign out_hold_ms    = frame.hold;
  assign out_last_frame = frame.last;

endmodule

`default_nettype wire

FILE: design/plbc_checker.sv
// ----------------------------------------------------------------------------
// plbc_checker
// port-level checks on the controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "proximity_led_bar_controller_macros.svh"

module plbc_checker
  import plbc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_push,
  input wire logic [FUNC_W-1:0]    in_func,
  input wire logic [DIST_W-1:0]    in_distance_cm,
  input wire logic                 in_full,
  input wire logic                 out_empty,
  input wire logic                 out_pop,
  input wire logic [DUTY_W-1:0]    out_led1_duty,
  input wire logic [DUTY_W-1:0]    out_led2_duty,
  input wire logic [DUTY_W-1:0]    out_led3_duty,
  input wire logic [DUTY_W-1:0]    out_led4_duty,
  input wire logic [HOLD_W-1:0]    out_hold_ms,
  input wire logic                 out_last_frame,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_W-1:0]     cfg_wdata
);

  // a stalled frame holds
  `PLBC_ASSERT_NXT(a_stall_hold, !out_empty && !out_pop, !out_empty && $stable(out_led1_duty) && $stable(out_led2_duty) && $stable(out_led3_duty) && $stable(out_led4_duty) && $stable(out_hold_ms) && $stable(out_last_frame))

  // a timed frame is never the final frame of its transaction
  `PLBC_ASSERT_IMP(a_hold_not_last, !out_empty && out_hold_ms != '0, !out_last_frame)

  // frames of one transaction follow without a gap
  `PLBC_ASSERT_NXT(a_no_gap, !out_empty && out_pop && !out_last_frame, !out_empty)

  // both channels come out of reset empty
  `PLBC_ASSERT_IMP(a_reset_empty, $past(!rst_n), out_empty && !in_full)

endmodule

bind proximity_led_bar_controller plbc_checker u_plbc_checker (.*);

`default_nettype wire

FILE: bench/proximity_led_bar_controller_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// proximity led bar controller checker
// Watches the command, frame and step time ports, keeps its own copy of the
// obstacle, blink and bar graph state, predicts every frame that an accepted
// command owes and compares popped frames field by field, oldest first.
// ----------------------------------------------------------------------------
module proximity_led_bar_controller_checker
  import plbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [DIST_W-1:0]    in_distance_cm,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic [DUTY_W-1:0]    out_led1_duty,
  input  logic [DUTY_W-1:0]    out_led2_duty,
  input  logic [DUTY_W-1:0]    out_led3_duty,
  input  logic [DUTY_W-1:0]    out_led4_duty,
  input  logic [HOLD_W-1:0]    out_hold_ms,
  input  logic                 out_last_frame,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   frames_pending
);

  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [HOLD_W-1:0] hold_t;

  typedef struct packed {
    duty_t led1;
    duty_t led2;
    duty_t led3;
    duty_t led4;
    hold_t hold;
    logic  last;
  } led_frame_t;

  localparam duty_t DARK           = '0;
  localparam hold_t NO_HOLD        = '0;
  localparam int    CASCADE_SWEEPS = 3;
  localparam int    SWEEP_LEN      = 6;
  localparam int    FLASH_BLINKS   = 5;

  // controller state as seen from outside
  logic  obstacle_on;
  logic  blink_on;
  duty_t bar_duty [NUM_LED];
  hold_t cascade_ms;
  hold_t flash_ms;

  // frames still owed by the controller, oldest first
  led_frame_t due_frames[$];

  function automatic void add_frame(input duty_t l1, input duty_t l2, input duty_t l3,
                                    input duty_t l4, input hold_t hold);
    led_frame_t fr;
    fr.led1 = l1;
    fr.led2 = l2;
    fr.led3 = l3;
    fr.led4 = l4;
    fr.hold = hold;
    fr.last = 1'b0;
    due_frames.push_back(fr);
  endfunction

  function automatic void add_bar_frame();
    add_frame(bar_duty[0], bar_duty[1], bar_duty[2], bar_duty[3], NO_HOLD);
  endfunction

  // distance to bar graph: led4 fills first, each led capped at full duty
  function automatic void load_bar_graph(input logic [DIST_W-1:0] dist_cm);
    int unsigned remain;
    remain = 0;
    if (dist_cm > FAR_CM) begin
      foreach (bar_duty[k]) bar_duty[k] = DARK;
    end else if (dist_cm <= NEAR_CM) begin
      foreach (bar_duty[k]) bar_duty[k] = FULL_DUTY;
    end else begin
      remain = 32'(FAR_CM - dist_cm) * 32'(STEP_PER_CM);
      for (int k = NUM_LED - 1; k >= 0; k--) begin
        if (remain > FULL_DUTY) begin
          bar_duty[k] = FULL_DUTY;
          remain      = remain - FULL_DUTY;
        end else begin
          bar_duty[k] = duty_t'(remain);
          remain      = 0;
        end
      end
    end
  endfunction

  // state update and owed frames for one accepted command
  function automatic void apply_command(input logic [FUNC_W-1:0] func,
                                        input logic [DIST_W-1:0] dist_cm);
    int         owed;
    int         lit;
    led_frame_t tail;
    owed = due_frames.size();
    case (func)
      FN_TICK: begin
        if (obstacle_on) begin
          blink_on = !blink_on;
          if (blink_on) add_frame(FULL_DUTY, FULL_DUTY, FULL_DUTY, FULL_DUTY, NO_HOLD);
          else          add_frame(DARK, DARK, DARK, DARK, NO_HOLD);
        end
      end
      FN_CLEAR: begin
        foreach (bar_duty[k]) bar_duty[k] = DARK;
        if (!obstacle_on) add_bar_frame();
      end
      FN_DISTANCE: begin
        load_bar_graph(dist_cm);
        if (!obstacle_on) add_bar_frame();
      end
      FN_OBS_ON: begin
        obstacle_on = 1'b1;
      end
      FN_OBS_OFF: begin
        obstacle_on = 1'b0;
        add_bar_frame();
      end
      FN_CASCADE: begin
        // blank frame, then sweeps led1..led4 and back, then the bar graph
        obstacle_on = 1'b0;
        add_frame(DARK, DARK, DARK, DARK, NO_HOLD);
        repeat (CASCADE_SWEEPS) begin
          for (int pos = 0; pos < SWEEP_LEN; pos++) begin
            lit = (pos < NUM_LED) ? pos : SWEEP_LEN - pos;
            add_frame((lit == 0) ? FULL_DUTY : DARK, (lit == 1) ? FULL_DUTY : DARK,
                      (lit == 2) ? FULL_DUTY : DARK, (lit == 3) ? FULL_DUTY : DARK,
                      cascade_ms);
          end
        end
        add_bar_frame();
      end
      FN_FLASH: begin
        obstacle_on = 1'b0;
        repeat (FLASH_BLINKS) begin
          add_frame(FULL_DUTY, FULL_DUTY, FULL_DUTY, FULL_DUTY, flash_ms);
          add_frame(DARK, DARK, DARK, DARK, flash_ms);
        end
        add_bar_frame();
      end
      default: begin
        // unused code, nothing changes
      end
    endcase
    // mark the closing frame of this command
    if (due_frames.size() > owed) begin
      tail      = due_frames.pop_back();
      tail.last = 1'b1;
      due_frames.push_back(tail);
    end
  endfunction

  function automatic void check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, field, want_v, got_v);
      fail_count++;
    end
  endfunction

  // one pass per edge: frames out first, then step times, then the command in
  always @(posedge clk) begin : watch
    led_frame_t want;
    led_frame_t got;
    if (!rst_n) begin
      due_frames.delete();
      obstacle_on = 1'b0;
      blink_on    = 1'b0;
      foreach (bar_duty[k]) bar_duty[k] = DARK;
      cascade_ms  = CASCADE_MS_RST;
      flash_ms    = FLASH_MS_RST;
      fail_count  = 0;
    end else begin
      if (out_pop && !out_empty) begin
        got.led1 = out_led1_duty;
        got.led2 = out_led2_duty;
        got.led3 = out_led3_duty;
        got.led4 = out_led4_duty;
        got.hold = out_hold_ms;
        got.last = out_last_frame;
        if (due_frames.size() == 0) begin
          $display("%0t: frame with no transaction behind it, expected none, %s",
                   $time, "actual below");
          $display("%0t:   actual %0d %0d %0d %0d hold %0d last %0d",
                   $time, got.led1, got.led2, got.led3, got.led4, got.hold, got.last);
          fail_count++;
        end else begin
          want = due_frames.pop_front();
          check_field("led1_duty", want.led1, got.led1);
          check_field("led2_duty", want.led2, got.led2);
          check_field("led3_duty", want.led3, got.led3);
          check_field("led4_duty", want.led4, got.led4);
          check_field("hold_ms", want.hold, got.hold);
          check_field("last_frame", want.last, got.last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CASCADE_MS: cascade_ms = cfg_wdata;
          CFG_FLASH_MS:   flash_ms   = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_push && !in_full) apply_command(in_func, in_distance_cm);
    end
    frames_pending <= due_frames.size();
  end

endmodule

FILE: bench/proximity_led_bar_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// proximity led bar controller test
// Drives directed and random command transactions with random idle cycles on
// both channels, rewrites the step times between phases while the block is
// drained, and reports the verdict from the checker's fail and pending counts.
// ----------------------------------------------------------------------------
module proximity_led_bar_controller_test;
  import plbc_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int PHASE_ITEMS = 49;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic [FUNC_W-1:0]    in_func;
  logic [DIST_W-1:0]    in_distance_cm;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop;
  logic [DUTY_W-1:0]    out_led1_duty;
  logic [DUTY_W-1:0]    out_led2_duty;
  logic [DUTY_W-1:0]    out_led3_duty;
  logic [DUTY_W-1:0]    out_led4_duty;
  logic [HOLD_W-1:0]    out_hold_ms;
  logic                 out_last_frame;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 calm;
  int                   fail_count;
  int                   frames_pending;

  proximity_led_bar_controller u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_func        (in_func),
    .in_distance_cm (in_distance_cm),
    .in_full        (in_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_led1_duty  (out_led1_duty),
    .out_led2_duty  (out_led2_duty),
    .out_led3_duty  (out_led3_duty),
    .out_led4_duty  (out_led4_duty),
    .out_hold_ms    (out_hold_ms),
    .out_last_frame (out_last_frame),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  proximity_led_bar_controller_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_distance_cm (in_distance_cm),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_led1_duty  (out_led1_duty),
    .out_led2_duty  (out_led2_duty),
    .out_led3_duty  (out_led3_duty),
    .out_led4_duty  (out_led4_duty),
    .out_hold_ms    (out_hold_ms),
    .out_last_frame (out_last_frame),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .frames_pending (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // frame receiver, stalls now and then unless calm
  always @(posedge clk) begin
    out_pop <= calm || ($urandom_range(99) >= 14);
  end

  // mostly near the bar graph range, sometimes anywhere
  function automatic logic [DIST_W-1:0] pick_distance();
    if ($urandom_range(9) < 7) return DIST_W'($urandom_range(0, 35));
    return DIST_W'($urandom_range(0, 1023));
  endfunction

  // one command transaction, push stays high afterwards
  task automatic send_command(input logic [FUNC_W-1:0] func,
                              input logic [DIST_W-1:0] dist_cm);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 14) gap++;
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_func        <= func;
    in_distance_cm <= dist_cm;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // stop sending and let every owed frame drain
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_step_times(input logic [CFG_W-1:0] cascade_ms,
                                  input logic [CFG_W-1:0] flash_ms);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CASCADE_MS;
    cfg_wdata <= cascade_ms;
    @(posedge clk);
    cfg_index <= CFG_FLASH_MS;
    cfg_wdata <= flash_ms;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random traffic, mostly obstacle episodes and distance updates
  task automatic random_commands(input int count);
    int sent;
    int pick;
    int steps;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_command(FN_OBS_ON, pick_distance());
        steps = $urandom_range(1, 6);
        repeat (steps) begin
          case ($urandom_range(3))
            0, 1:    send_command(FN_TICK, pick_distance());
            2:       send_command(FN_DISTANCE, pick_distance());
            default: send_command(FN_CLEAR, pick_distance());
          endcase
        end
        case ($urandom_range(5))
          4:       send_command(FN_CASCADE, pick_distance());
          5:       send_command(FN_FLASH, pick_distance());
          default: send_command(FN_OBS_OFF, pick_distance());
        endcase
        sent += steps + 2;
      end else if (pick < 55) begin
        send_command(FN_DISTANCE, pick_distance());
        sent++;
      end else if (pick < 63) begin
        send_command(FN_TICK, pick_distance());
        sent++;
      end else if (pick < 70) begin
        send_command(FN_CLEAR, pick_distance());
        sent++;
      end else if (pick < 78) begin
        send_command(FN_OBS_ON, pick_distance());
        sent++;
      end else if (pick < 85) begin
        send_command(FN_OBS_OFF, pick_distance());
        sent++;
      end else if (pick < 90) begin
        send_command(FN_CASCADE, pick_distance());
        sent++;
      end else if (pick < 96) begin
        send_command(FN_FLASH, pick_distance());
        sent++;
      end else begin
        send_command(FN_UNUSED, pick_distance());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_func        = FN_TICK;
    in_distance_cm = '0;
    out_pop        = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_CASCADE_MS;
    cfg_wdata      = '0;
    calm           = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // bar graph corners and boundaries
    send_command(FN_DISTANCE, 10'd0);
    send_command(FN_DISTANCE, NEAR_CM);
    send_command(FN_DISTANCE, 10'd6);
    send_command(FN_DISTANCE, 10'd12);
    send_command(FN_DISTANCE, 10'd18);
    send_command(FN_DISTANCE, 10'd29);
    send_command(FN_DISTANCE, FAR_CM);
    send_command(FN_DISTANCE, 10'd31);
    send_command(FN_DISTANCE, 10'd1023);
    send_command(FN_CLEAR, 10'd1023);
    // tick without obstacle and the unused code give nothing
    send_command(FN_TICK, 10'd0);
    send_command(FN_UNUSED, 10'd7);
    // obstacle episode: blink, saved updates hidden, stop restores
    send_command(FN_DISTANCE, 10'd20);
    send_command(FN_OBS_ON, 10'd0);
    send_command(FN_TICK, 10'd0);
    send_command(FN_TICK, 10'd0);
    send_command(FN_DISTANCE, 10'd8);
    send_command(FN_CLEAR, 10'd0);
    send_command(FN_DISTANCE, 10'd15);
    send_command(FN_OBS_ON, 10'd0);
    send_command(FN_OBS_OFF, 10'd0);
    send_command(FN_OBS_OFF, 10'd0);
    // patterns, each clears the obstacle
    send_command(FN_CASCADE, 10'd0);
    send_command(FN_OBS_ON, 10'd0);
    send_command(FN_FLASH, 10'd0);
    send_command(FN_TICK, 10'd0);

    random_commands(PHASE_ITEMS);
    wait_idle();

    calm <= 1'b1;
    write_step_times(10'd0, 10'd1000);
    random_commands(PHASE_ITEMS);
    wait_idle();

    calm <= 1'b0;
    write_step_times(10'd1023, 10'd0);
    random_commands(PHASE_ITEMS);
    wait_idle();

    write_step_times(CFG_W'($urandom_range(0, 1023)), CFG_W'($urandom_range(0, 1023)));
    random_commands(PHASE_ITEMS);
    wait_idle();

    if (fail_count == 0 && frames_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/plbc_pkg.sv
design/plbc_front.sv
design/plbc_cmdq.sv
design/plbc_back.sv
design/proximity_led_bar_controller.sv
design/plbc_checker.sv
bench/proximity_led_bar_controller_checker.sv
bench/proximity_led_bar_controller_test.sv
